// ===== rtl/core/lav_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lav_pkg
// Shared widths, types and arithmetic helpers of the look-at view matrix unit.
// ---------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int UNIT_W     = FRAC_BITS + 2;
  localparam int VEC_W      = (2 * FRAC_BITS + 4 > 36) ? 2 * FRAC_BITS + 4 : 36;
  localparam int POS_W      = $clog2(VEC_W);
  localparam int NRM_W      = 30;
  localparam int SQ_W       = 2 * NRM_W + 2;
  localparam int LEN_W      = NRM_W + 1;
  localparam int SQ_STEPS   = NRM_W + 1;
  localparam int SQ_STAGES  = (SQ_STEPS + 1) / 2;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int DIV_STAGES = (DIV_STEPS + 1) / 2;
  localparam int DIV_W      = LEN_W + FRAC_BITS + 1;
  localparam int UNIT_LAT   = SQ_STAGES + DIV_STAGES + 7;
  localparam int P_W        = COORD_W + 4;
  localparam int PR_W       = UNIT_W + COORD_W;
  localparam int FP_W       = UNIT_W + P_W;
  localparam int CP_W       = 2 * UNIT_W;
  localparam int SUM_W      = PR_W + 2;

  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } sq_state_t;

  typedef struct packed {
    logic [DIV_W-1:0]   rem;
    logic [FRAC_BITS:0] q;
  } div_state_t;

  // Two steps of the digit-by-digit square root, starting at step first.
  function automatic sq_state_t sqrt_steps(sq_state_t s, int first);
    sq_state_t       o;
    logic [SQ_W-1:0] b;
    o = s;
    for (int j = 0; j < 2; j++) begin
      if (first + j < SQ_STEPS) begin
        b = SQ_W'(1) << (2 * (SQ_STEPS - 1 - (first + j)));
        if (o.n >= o.r + b) begin
          o.n = o.n - (o.r + b);
          o.r = (o.r >> 1) + b;
        end else begin
          o.r = o.r >> 1;
        end
      end
    end
    return o;
  endfunction

  // Two steps of restoring division, one quotient bit per step, MSB first.
  function automatic div_state_t div_steps(div_state_t s, logic [LEN_W-1:0] len,
                                           int first);
    div_state_t       o;
    logic [DIV_W-1:0] d;
    o = s;
    for (int j = 0; j < 2; j++) begin
      if (first + j < DIV_STEPS) begin
        d = DIV_W'(len) << (FRAC_BITS - (first + j));
        if (o.rem >= d) begin
          o.rem = o.rem - d;
          o.q[FRAC_BITS - (first + j)] = 1'b1;
        end
      end
    end
    return o;
  endfunction

  // Round half up and drop the fraction bits.
  function automatic logic signed [63:0] rnd(logic signed [63:0] x);
    logic signed [63:0] half;
    half = 64'sd1 <<< (FRAC_BITS - 1);
    return (x + half) >>> FRAC_BITS;
  endfunction

  function automatic coord_t sat32(logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      return coord_t'(hi[COORD_W-1:0]);
    end else if (x < lo) begin
      return coord_t'(lo[COORD_W-1:0]);
    end
    return coord_t'(x[COORD_W-1:0]);
  endfunction

endpackage

// ===== rtl/core/lav_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lav_unit
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
// ---------------------------------------------------------------------------
module lav_unit
  import lav_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  vec_t  v [3],
  output logic  out_valid,
  output unit_t u [3],
  output logic  ok
);

  // Magnitudes and the largest of them
  logic [VEC_W-1:0] m_abs [3];
  logic [VEC_W-1:0] top_c;
  logic             a_valid;
  logic [2:0]       a_neg;
  logic [VEC_W-1:0] a_m [3];
  logic [VEC_W-1:0] a_top;

  always_comb begin
    top_c = '0;
    for (int i = 0; i < 3; i++) begin
      m_abs[i] = v[i][VEC_W-1] ? VEC_W'(-v[i]) : VEC_W'(v[i]);
      if (m_abs[i] > top_c) begin
        top_c = m_abs[i];
      end
    end
  end

  // Leading one position
  logic [POS_W-1:0] pos_c;
  logic             b_valid;
  logic [POS_W-1:0] b_pos;
  logic             b_zero;
  logic [2:0]       b_neg;
  logic [VEC_W-1:0] b_m [3];

  always_comb begin
    pos_c = '0;
    for (int k = 0; k < VEC_W; k++) begin
      if (a_top[k]) begin
        pos_c = POS_W'(k);
      end
    end
  end

  // Common shift so that the largest lies in [2^29, 2^30)
  logic [VEC_W-1:0] sh_c [3];
  logic             c_valid;
  logic             c_zero;
  logic [2:0]       c_neg;
  logic [NRM_W-1:0] c_m [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_pos >= POS_W'(NRM_W)) begin
        sh_c[i] = b_m[i] >> (b_pos - POS_W'(NRM_W - 1));
      end else begin
        sh_c[i] = b_m[i] << (POS_W'(NRM_W - 1) - b_pos);
      end
    end
  end

  // Squares
  logic               d_valid;
  logic               d_zero;
  logic [2:0]         d_neg;
  logic [NRM_W-1:0]   d_m [3];
  logic [2*NRM_W-1:0] d_sq [3];

  // Square root stages
  sq_state_t        sq_st    [SQ_STAGES+1];
  logic [NRM_W-1:0] sq_m     [SQ_STAGES+1][3];
  logic [2:0]       sq_neg   [SQ_STAGES+1];
  logic             sq_zero  [SQ_STAGES+1];
  logic             sq_valid [SQ_STAGES+1];

  // Division stages
  logic [LEN_W-1:0] len_c;
  div_state_t       dv_st    [DIV_STAGES+1][3];
  logic [LEN_W-1:0] dv_len   [DIV_STAGES+1];
  logic [2:0]       dv_neg   [DIV_STAGES+1];
  logic             dv_zero  [DIV_STAGES+1];
  logic             dv_valid [DIV_STAGES+1];

  assign len_c = sq_st[SQ_STAGES].r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      d_valid     <= 1'b0;
      sq_valid[0] <= 1'b0;
      dv_valid[0] <= 1'b0;
      out_valid   <= 1'b0;
    end else if (en) begin
      a_valid     <= in_valid;
      b_valid     <= a_valid;
      c_valid     <= b_valid;
      d_valid     <= c_valid;
      sq_valid[0] <= d_valid;
      dv_valid[0] <= sq_valid[SQ_STAGES];
      out_valid   <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i]  <= v[i][VEC_W-1];
        a_m[i]    <= m_abs[i];
        b_m[i]    <= a_m[i];
        c_m[i]    <= sh_c[i][NRM_W-1:0];
        d_m[i]    <= c_m[i];
        d_sq[i]   <= (2*NRM_W)'(c_m[i]) * (2*NRM_W)'(c_m[i]);
        sq_m[0][i] <= d_m[i];
        dv_st[0][i].rem <= (DIV_W'(sq_m[SQ_STAGES][i]) << FRAC_BITS)
                           + DIV_W'(len_c >> 1);
        dv_st[0][i].q   <= '0;
        if (dv_zero[DIV_STAGES]) begin
          u[i] <= '0;
        end else if (dv_neg[DIV_STAGES][i]) begin
          u[i] <= -unit_t'({1'b0, dv_st[DIV_STAGES][i].q});
        end else begin
          u[i] <= unit_t'({1'b0, dv_st[DIV_STAGES][i].q});
        end
      end
      a_top      <= top_c;
      b_pos      <= pos_c;
      b_zero     <= (a_top == '0);
      b_neg      <= a_neg;
      c_zero     <= b_zero;
      c_neg      <= b_neg;
      d_zero     <= c_zero;
      d_neg      <= c_neg;
      sq_st[0].n <= SQ_W'(d_sq[0]) + SQ_W'(d_sq[1]) + SQ_W'(d_sq[2]);
      sq_st[0].r <= '0;
      sq_neg[0]  <= d_neg;
      sq_zero[0] <= d_zero;
      dv_len[0]  <= len_c;
      dv_neg[0]  <= sq_neg[SQ_STAGES];
      dv_zero[0] <= sq_zero[SQ_STAGES];
      ok         <= !dv_zero[DIV_STAGES];
    end
  end

  for (genvar gs = 0; gs < SQ_STAGES; gs++) begin : g_sq
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[gs+1] <= 1'b0;
      end else if (en) begin
        sq_valid[gs+1] <= sq_valid[gs];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_st[gs+1]   <= sqrt_steps(sq_st[gs], 2 * gs);
        sq_m[gs+1]    <= sq_m[gs];
        sq_neg[gs+1]  <= sq_neg[gs];
        sq_zero[gs+1] <= sq_zero[gs];
      end
    end
  end

  for (genvar gd = 0; gd < DIV_STAGES; gd++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[gd+1] <= 1'b0;
      end else if (en) begin
        dv_valid[gd+1] <= dv_valid[gd];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_st[gd+1][i] <= div_steps(dv_st[gd][i], dv_len[gd], 2 * gd);
        end
        dv_len[gd+1]  <= dv_len[gd];
        dv_neg[gd+1]  <= dv_neg[gd];
        dv_zero[gd+1] <= dv_zero[gd];
      end
    end
  end

endmodule

// ===== rtl/core/look_at_view_matrix_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// look_at_view_matrix_unit
// Builds a fixed-point look-at view matrix from eye, target and up hint.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item carries eye, target and up hint (nine signed
//   Q16.16 words). Output channel m_*: four row items per input item, rows
//   0..2 hold the right/up/forward basis parts, row 3 the translations.
//   m_tlast marks row 3; m_tuser carries the row number and the degenerate
//   flag (a zero-length vector, all columns then read zero).
// Depth: the three normalizers (scale, square, 31-step square root, 17-step
//   divide) set most of the pipeline depth from the input handshake to the
//   first row on m_tvalid.
// Throughput: an item may enter in every cycle while the pipe drains; the
//   sustained rate is set by the four-row output serializer, which takes a
//   new matrix while its last row is being taken.
// Reset: clears all valid bits; nothing is pending afterward.
// Stall: when m_tready is low the serializer holds its row, the finished
//   matrix behind it waits, and the whole pipe freezes with s_tready low;
//   no item is lost or repeated.
// ---------------------------------------------------------------------------
module look_at_view_matrix_unit
  import lav_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_hint_x, up_hint_y,
  // up_hint_z (32 bits each, from bit 0 up)
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // col_zero, col_one, col_two (32 bits each, from bit 0 up)
  output logic [95:0]  m_tdata,
  output logic         m_tlast,
  // row_index (bits 1:0), degenerate (bit 2)
  output logic [2:0]   m_tuser
);

  logic en;
  logic fin_valid;
  logic fin_take;

  // Global advance: the pipe moves when its last slot is free or drains now
  assign en       = !fin_valid || fin_take;
  assign s_tready = en;

  // Input register: unpack and form target minus eye
  coord_t in_e [3];
  coord_t in_t [3];
  coord_t in_h [3];
  logic   s0_valid;
  vec_t   s0_d [3];
  coord_t s0_e [3];
  coord_t s0_h [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_e[i] = s_tdata[COORD_W*i +: COORD_W];
      in_t[i] = s_tdata[COORD_W*(i+3) +: COORD_W];
      in_h[i] = s_tdata[COORD_W*(i+6) +: COORD_W];
    end
  end

  // Forward normalizer and its side delay line
  logic   u1_valid;
  unit_t  u1_u [3];
  logic   u1_ok;
  coord_t d1_e [UNIT_LAT][3];
  coord_t d1_h [UNIT_LAT][3];

  lav_unit u_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s0_valid),
    .v        (s0_d),
    .out_valid(u1_valid),
    .u        (u1_u),
    .ok       (u1_ok)
  );

  // Projection of the hint on forward
  logic              p1_valid, p2_valid, p3_valid, p4_valid, p5_valid;
  logic              p1_ok, p2_ok, p3_ok, p4_ok, p5_ok;
  unit_t             p1_f [3];
  unit_t             p2_f [3];
  unit_t             p3_f [3];
  unit_t             p4_f [3];
  unit_t             p5_f [3];
  coord_t            p1_e [3];
  coord_t            p2_e [3];
  coord_t            p3_e [3];
  coord_t            p4_e [3];
  coord_t            p5_e [3];
  coord_t            p1_h [3];
  coord_t            p2_h [3];
  coord_t            p3_h [3];
  coord_t            p4_h [3];
  logic signed [PR_W-1:0] p2_fh [3];
  logic signed [P_W-1:0]  p3_p;
  logic signed [FP_W-1:0] p4_fp [3];
  vec_t              p5_w [3];

  // Up normalizer and its side delay line
  logic   u2_valid;
  unit_t  u2_u [3];
  logic   u2_ok;
  coord_t d2_e  [UNIT_LAT][3];
  unit_t  d2_f  [UNIT_LAT][3];
  logic   d2_ok [UNIT_LAT];

  lav_unit u_up (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p5_valid),
    .v        (p5_w),
    .out_valid(u2_valid),
    .u        (u2_u),
    .ok       (u2_ok)
  );

  // Cross product up x forward
  logic                   c1_valid, c2_valid;
  logic                   c1_ok, c2_ok;
  logic signed [CP_W-1:0] c1_pr [6];
  unit_t                  c1_up [3];
  unit_t                  c2_up [3];
  unit_t                  c1_f  [3];
  unit_t                  c2_f  [3];
  coord_t                 c1_e  [3];
  coord_t                 c2_e  [3];
  vec_t                   c2_c  [3];

  // Right normalizer and its side delay line
  logic   u3_valid;
  unit_t  u3_u [3];
  logic   u3_ok;
  coord_t d3_e  [UNIT_LAT][3];
  unit_t  d3_up [UNIT_LAT][3];
  unit_t  d3_f  [UNIT_LAT][3];
  logic   d3_ok [UNIT_LAT];

  lav_unit u_right (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c2_valid),
    .v        (c2_c),
    .out_valid(u3_valid),
    .u        (u3_u),
    .ok       (u3_ok)
  );

  // Translation row: basis dot eye, round, negate, saturate
  logic                    t1_valid, t2_valid;
  logic                    t1_ok, t2_ok, fin_ok;
  logic signed [PR_W-1:0]  t1_pr [3][3];
  logic signed [SUM_W-1:0] t2_s  [3];
  unit_t                   t1_b  [3][3];
  unit_t                   t2_b  [3][3];
  unit_t                   fin_b [3][3];
  coord_t                  fin_t [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      p4_valid  <= 1'b0;
      p5_valid  <= 1'b0;
      c1_valid  <= 1'b0;
      c2_valid  <= 1'b0;
      t1_valid  <= 1'b0;
      t2_valid  <= 1'b0;
      fin_valid <= 1'b0;
    end else if (en) begin
      s0_valid  <= s_tvalid;
      p1_valid  <= u1_valid;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      p4_valid  <= p3_valid;
      p5_valid  <= p4_valid;
      c1_valid  <= u2_valid;
      c2_valid  <= c1_valid;
      t1_valid  <= u3_valid;
      t2_valid  <= t1_valid;
      fin_valid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_d[i] <= VEC_W'(in_t[i]) - VEC_W'(in_e[i]);
        s0_e[i] <= in_e[i];
        s0_h[i] <= in_h[i];
      end

      d1_e[0] <= s0_e;
      d1_h[0] <= s0_h;
      for (int k = 1; k < UNIT_LAT; k++) begin
        d1_e[k] <= d1_e[k-1];
        d1_h[k] <= d1_h[k-1];
      end

      // Forward is the negated unit vector toward the target
      for (int i = 0; i < 3; i++) begin
        p1_f[i] <= -u1_u[i];
      end
      p1_e  <= d1_e[UNIT_LAT-1];
      p1_h  <= d1_h[UNIT_LAT-1];
      p1_ok <= u1_ok;

      for (int i = 0; i < 3; i++) begin
        p2_fh[i] <= PR_W'(p1_f[i]) * PR_W'(p1_h[i]);
      end
      p2_f  <= p1_f;
      p2_e  <= p1_e;
      p2_h  <= p1_h;
      p2_ok <= p1_ok;

      p3_p  <= P_W'(rnd(64'(p2_fh[0]) + 64'(p2_fh[1]) + 64'(p2_fh[2])));
      p3_f  <= p2_f;
      p3_e  <= p2_e;
      p3_h  <= p2_h;
      p3_ok <= p2_ok;

      for (int i = 0; i < 3; i++) begin
        p4_fp[i] <= FP_W'(p3_f[i]) * FP_W'(p3_p);
      end
      p4_f  <= p3_f;
      p4_e  <= p3_e;
      p4_h  <= p3_h;
      p4_ok <= p3_ok;

      for (int i = 0; i < 3; i++) begin
        p5_w[i] <= VEC_W'(p4_h[i]) - VEC_W'(rnd(64'(p4_fp[i])));
      end
      p5_f  <= p4_f;
      p5_e  <= p4_e;
      p5_ok <= p4_ok;

      d2_e[0]  <= p5_e;
      d2_f[0]  <= p5_f;
      d2_ok[0] <= p5_ok;
      for (int k = 1; k < UNIT_LAT; k++) begin
        d2_e[k]  <= d2_e[k-1];
        d2_f[k]  <= d2_f[k-1];
        d2_ok[k] <= d2_ok[k-1];
      end

      c1_pr[0] <= CP_W'(u2_u[1]) * CP_W'(d2_f[UNIT_LAT-1][2]);
      c1_pr[1] <= CP_W'(u2_u[2]) * CP_W'(d2_f[UNIT_LAT-1][1]);
      c1_pr[2] <= CP_W'(u2_u[2]) * CP_W'(d2_f[UNIT_LAT-1][0]);
      c1_pr[3] <= CP_W'(u2_u[0]) * CP_W'(d2_f[UNIT_LAT-1][2]);
      c1_pr[4] <= CP_W'(u2_u[0]) * CP_W'(d2_f[UNIT_LAT-1][1]);
      c1_pr[5] <= CP_W'(u2_u[1]) * CP_W'(d2_f[UNIT_LAT-1][0]);
      c1_up    <= u2_u;
      c1_f     <= d2_f[UNIT_LAT-1];
      c1_e     <= d2_e[UNIT_LAT-1];
      c1_ok    <= d2_ok[UNIT_LAT-1] && u2_ok;

      for (int i = 0; i < 3; i++) begin
        c2_c[i] <= VEC_W'(c1_pr[2*i]) - VEC_W'(c1_pr[2*i+1]);
      end
      c2_up <= c1_up;
      c2_f  <= c1_f;
      c2_e  <= c1_e;
      c2_ok <= c1_ok;

      d3_e[0]  <= c2_e;
      d3_up[0] <= c2_up;
      d3_f[0]  <= c2_f;
      d3_ok[0] <= c2_ok;
      for (int k = 1; k < UNIT_LAT; k++) begin
        d3_e[k]  <= d3_e[k-1];
        d3_up[k] <= d3_up[k-1];
        d3_f[k]  <= d3_f[k-1];
        d3_ok[k] <= d3_ok[k-1];
      end

      // Rows of the basis: right, up, forward
      for (int i = 0; i < 3; i++) begin
        t1_pr[0][i] <= PR_W'(u3_u[i]) * PR_W'(d3_e[UNIT_LAT-1][i]);
        t1_pr[1][i] <= PR_W'(d3_up[UNIT_LAT-1][i]) * PR_W'(d3_e[UNIT_LAT-1][i]);
        t1_pr[2][i] <= PR_W'(d3_f[UNIT_LAT-1][i]) * PR_W'(d3_e[UNIT_LAT-1][i]);
      end
      t1_b[0] <= u3_u;
      t1_b[1] <= d3_up[UNIT_LAT-1];
      t1_b[2] <= d3_f[UNIT_LAT-1];
      t1_ok   <= d3_ok[UNIT_LAT-1] && u3_ok;

      for (int j = 0; j < 3; j++) begin
        t2_s[j] <= SUM_W'(t1_pr[j][0]) + SUM_W'(t1_pr[j][1]) + SUM_W'(t1_pr[j][2]);
      end
      t2_b  <= t1_b;
      t2_ok <= t1_ok;

      for (int j = 0; j < 3; j++) begin
        fin_t[j] <= sat32(-rnd(64'(t2_s[j])));
      end
      fin_b  <= t2_b;
      fin_ok <= t2_ok;
    end
  end

  // Row serializer: hold one matrix, emit its four rows
  logic       busy;
  logic [1:0] row;
  logic       o_ok;
  unit_t      o_b [3][3];
  coord_t     o_t [3];
  coord_t     col0, col1, col2;

  assign fin_take = fin_valid && (!busy || (m_tready && row == LAST_ROW));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= '0;
    end else if (fin_take) begin
      busy <= 1'b1;
      row  <= '0;
    end else if (busy && m_tready) begin
      if (row == LAST_ROW) begin
        busy <= 1'b0;
      end
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      o_b  <= fin_b;
      o_t  <= fin_t;
      o_ok <= fin_ok;
    end
  end

  always_comb begin
    col0 = '0;
    col1 = '0;
    col2 = '0;
    if (o_ok) begin
      if (row == LAST_ROW) begin
        col0 = o_t[0];
        col1 = o_t[1];
        col2 = o_t[2];
      end else begin
        col0 = coord_t'(o_b[0][row]);
        col1 = coord_t'(o_b[1][row]);
        col2 = coord_t'(o_b[2][row]);
      end
    end
  end

  assign m_tvalid = busy;
  assign m_tdata  = {col2, col1, col0};
  assign m_tlast  = (row == LAST_ROW);
  assign m_tuser  = {!o_ok, row};

endmodule

// ===== dv/look_at_view_matrix_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// look_at_view_matrix_unit_tb
// Self-checking bench for the look-at view matrix unit: a fixed-point
// predictor builds the four expected rows of every accepted item, and every
// row the block returns is checked in order, field by field.
// ---------------------------------------------------------------------------
module look_at_view_matrix_unit_tb;
  import lav_pkg::*;

  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic               degen;
    logic               last;
  } view_row_t;

  // Predict the view matrix and compare the returned rows against it.
  class view_matrix_board;
    view_row_t pending_rows[$];
    int        errors;
    int        rows_seen;
    int        degen_seen;

    function automatic longint floor_shift(longint x, int s);
      return x < 0 ? -64'sd1 - ((-64'sd1 - x) >>> s) : x >>> s;
    endfunction

    function automatic longint round_frac(longint x);
      return floor_shift(x + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
    endfunction

    function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Scale to a common range, take the length, divide with rounding.
    function automatic bit normalize(input longint v[3], output longint u[3]);
      longint unsigned mag[3];
      longint unsigned top;
      longint unsigned len;
      longint unsigned q;
      top = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = v[i] < 0 ? -v[i] : v[i];
        if (mag[i] > top) top = mag[i];
      end
      if (top == 0) begin
        u = '{0, 0, 0};
        return 0;
      end
      while (top >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
        top >>= 1;
      end
      while (top < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
        top <<= 1;
      end
      len = root_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << FRAC_BITS) + len / 2) / len;
        u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function void note_item(logic [287:0] word);
      longint eye[3], hint[3], dir[3], fwd[3], resid[3], upv[3], crs[3], rgt[3];
      longint trans[3];
      longint proj;
      bit ok;
      view_row_t r;
      for (int i = 0; i < 3; i++) begin
        eye[i]  = longint'($signed(word[32*i +: 32]));
        dir[i]  = longint'($signed(word[32*(i+3) +: 32])) - eye[i];
        hint[i] = longint'($signed(word[32*(i+6) +: 32]));
      end
      ok = normalize(dir, fwd);
      for (int i = 0; i < 3; i++) fwd[i] = -fwd[i];
      proj = round_frac(fwd[0] * hint[0] + fwd[1] * hint[1] + fwd[2] * hint[2]);
      for (int i = 0; i < 3; i++) resid[i] = hint[i] - round_frac(fwd[i] * proj);
      if (!normalize(resid, upv)) ok = 0;
      crs[0] = upv[1] * fwd[2] - upv[2] * fwd[1];
      crs[1] = upv[2] * fwd[0] - upv[0] * fwd[2];
      crs[2] = upv[0] * fwd[1] - upv[1] * fwd[0];
      if (!normalize(crs, rgt)) ok = 0;
      trans[0] = clamp32(-round_frac(rgt[0] * eye[0] + rgt[1] * eye[1] + rgt[2] * eye[2]));
      trans[1] = clamp32(-round_frac(upv[0] * eye[0] + upv[1] * eye[1] + upv[2] * eye[2]));
      trans[2] = clamp32(-round_frac(fwd[0] * eye[0] + fwd[1] * eye[1] + fwd[2] * eye[2]));
      for (int i = 0; i < 4; i++) begin
        r.row   = i[1:0];
        r.degen = !ok;
        r.last  = (i[1:0] == LAST_ROW);
        r.c0 = 0;
        r.c1 = 0;
        r.c2 = 0;
        if (ok && i < 3) begin
          r.c0 = rgt[i][31:0];
          r.c1 = upv[i][31:0];
          r.c2 = fwd[i][31:0];
        end else if (ok) begin
          r.c0 = trans[0][31:0];
          r.c1 = trans[1][31:0];
          r.c2 = trans[2][31:0];
        end
        pending_rows.push_back(r);
      end
      if (!ok) degen_seen++;
    endfunction

    function void check_row(logic [95:0] data, logic last, logic [2:0] user);
      view_row_t e;
      rows_seen++;
      if (pending_rows.size() == 0) begin
        $display("%0t: row with nothing pending: data=%h user=%h", $time, data, user);
        errors++;
        return;
      end
      e = pending_rows.pop_front();
      if (user[1:0] !== e.row) begin
        $display("%0t: row_index exp %0d got %0d", $time, e.row, user[1:0]);
        errors++;
      end
      if (user[2] !== e.degen) begin
        $display("%0t: degenerate exp %0b got %0b", $time, e.degen, user[2]);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_row exp %0b got %0b", $time, e.last, last);
        errors++;
      end
      if (data[31:0] !== e.c0) begin
        $display("%0t: col_zero exp %h got %h", $time, e.c0, data[31:0]);
        errors++;
      end
      if (data[63:32] !== e.c1) begin
        $display("%0t: col_one exp %h got %h", $time, e.c1, data[63:32]);
        errors++;
      end
      if (data[95:64] !== e.c2) begin
        $display("%0t: col_two exp %h got %h", $time, e.c2, data[95:64]);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 3 * UNIT_LAT + 40;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;
  logic         m_tlast;
  logic [2:0]   m_tuser;

  view_matrix_board board;
  bit   hold_sink;
  int   idle_cycles;
  int   items_sent;

  look_at_view_matrix_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offer one item at the falling edge and hold it until the handshake.
  task automatic send_item(logic [287:0] word);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    board.note_item(word);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [287:0] pack_item(logic [31:0] e[3], logic [31:0] t[3],
                                             logic [31:0] h[3]);
    return {h[2], h[1], h[0], t[2], t[1], t[0], e[2], e[1], e[0]};
  endfunction

  // Random coordinate: mostly modest magnitudes, sometimes full range.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000);
      default: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
    endcase
  endfunction

  task automatic run_stimulus();
    logic [31:0] e[3], t[3], h[3];
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h1};
    // Plain camera: eye at z=5, look at origin, y up.
    send_item(pack_item('{0, 0, 32'h0005_0000}, '{0, 0, 0}, '{0, 32'h0001_0000, 0}));
    // Target equals eye: zero-length forward.
    send_item(pack_item('{32'h0001_0000, 2, 3}, '{32'h0001_0000, 2, 3}, '{0, 1, 0}));
    // Up hint parallel to forward: zero up residual.
    send_item(pack_item('{0, 0, 0}, '{0, 32'h0003_0000, 0}, '{0, 32'h0001_0000, 0}));
    // Zero up hint.
    send_item(pack_item('{5, 6, 7}, '{100, 200, 300}, '{0, 0, 0}));
    // Far eye: translation saturates.
    send_item(pack_item('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                        '{32'h8000_0000, 32'h7FFF_FFFF, 0}));
    send_item(pack_item('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF},
                        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000},
                        '{32'h7FFF_FFFF, 0, 32'h8000_0000}));
    // Extremes of every field, mixed.
    for (int k = 0; k < 14; k++) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = edges[$urandom_range(0, 5)];
        t[i] = edges[$urandom_range(0, 5)];
        h[i] = edges[$urandom_range(0, 5)];
      end
      send_item(pack_item(e, t, h));
    end
    // Random part, with a few collinear and coincident cases mixed in.
    for (int k = 0; k < 160; k++) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = rand_coord();
        t[i] = rand_coord();
        h[i] = rand_coord();
      end
      case ($urandom_range(0, 19))
        0: t = e;
        1: h = '{0, 0, 0};
        2: for (int i = 0; i < 3; i++) h[i] = t[i] - e[i];
        default: ;
      endcase
      send_item(pack_item(e, t, h));
    end
    s_tvalid <= 1'b0;
  endtask

  // Sink: random stalls per row; the long hold forces back-pressure.
  initial begin
    int wait_n;
    m_tready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end else begin
        wait_n = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) wait_n = 0;
        if (wait_n != 0) begin
          m_tready <= 1'b0;
          repeat (wait_n) @(negedge clk);
        end
        m_tready <= 1'b1;
        do @(posedge clk); while (!m_tvalid);
        @(negedge clk);
      end
    end
  end

  // Long receiver hold-off early in the random part so the pipe fills.
  initial begin
    hold_sink = 1'b0;
    wait (items_sent == 30);
    hold_sink = 1'b1;
    repeat (400) @(posedge clk);
    hold_sink = 1'b0;
  end

  // Check rows and track progress for the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_row(m_tdata, m_tlast, m_tuser);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || hold_sink) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    board       = new();
    items_sent  = 0;
    idle_cycles = 0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_stimulus();
    while (board.pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items (%0d degenerate), %0d rows checked, with random stalls",
             items_sent, board.degen_seen, board.rows_seen);
    $display("and one long output hold that back-pressured the input.");
    if (board.errors == 0 && board.pending_rows.size() == 0) begin
      $display("look_at_view_matrix_unit regression: pass");
    end else begin
      $display("look_at_view_matrix_unit regression: fail");
    end
    $finish;
  end

  // Watchdog: stop if nothing moves for too long.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no progress for %0d cycles, %0d rows outstanding", $time,
             WATCHDOG_LIMIT, board.pending_rows.size());
    $display("look_at_view_matrix_unit regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lav_pkg.sv
rtl/core/lav_unit.sv
rtl/core/look_at_view_matrix_unit.sv
dv/look_at_view_matrix_unit_tb.sv
